// ===== rtl/core/bmpdec_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpdec_pkg
// Types and constants shared by the 24-bit BMP to RGBA decoder modules.
// ----------------------------------------------------------------------------
package bmpdec_pkg;

  localparam int unsigned MAX_DIM = 4096;

  localparam logic [2:0] KIND_INFO     = 3'd0;
  localparam logic [2:0] KIND_PIXEL    = 3'd1;
  localparam logic [2:0] KIND_BAD_SIG  = 3'd2;
  localparam logic [2:0] KIND_BAD_BPP  = 3'd3;
  localparam logic [2:0] KIND_TOO_BIG  = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PIXELS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } bmpdec_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [11:0] col;
    logic [11:0] row;
    logic [12:0] tex_width;
    logic [12:0] tex_height;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last;
  } bmpdec_out_t;

endpackage

// ===== rtl/core/bmpdec_parse.sv =====
// ----------------------------------------------------------------------------
// bmpdec_parse
// Header parser and pixel assembler: consumes one file byte per step and
// produces at most one result for it.
// ----------------------------------------------------------------------------
module bmpdec_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  bmpdec_pkg::bmpdec_in_t   item,
  output logic                     res_valid,
  output bmpdec_pkg::bmpdec_out_t  res
);
  import bmpdec_pkg::*;

  localparam logic [5:0] HDR_SIG_HI   = 6'd1;
  localparam logic [5:0] HDR_W_LO     = 6'd18;
  localparam logic [5:0] HDR_W_HI     = 6'd21;
  localparam logic [5:0] HDR_H_LO     = 6'd22;
  localparam logic [5:0] HDR_H_HI     = 6'd25;
  localparam logic [5:0] HDR_BPP_LO   = 6'd28;
  localparam logic [5:0] HDR_BPP_HI   = 6'd29;
  localparam logic [5:0] HDR_LAST     = 6'd53;
  localparam logic [15:0] SIGNATURE   = 16'h4D42;
  localparam logic [15:0] BPP_24      = 16'd24;
  localparam logic [7:0]  FULL        = 8'hFF;

  phase_t      phase_r, phase_nxt, phase_eff;
  logic [5:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [15:0] sig_r, sig_nxt;
  logic [31:0] width_r, width_nxt;
  logic [31:0] height_r, height_nxt;
  logic [15:0] bpp_r, bpp_nxt;
  logic [12:0] col_cnt_r, col_cnt_nxt;
  logic [12:0] frow_cnt_r, frow_cnt_nxt;
  logic [1:0]  byte_ph_r, byte_ph_nxt;
  logic [1:0]  pad_cnt_r, pad_cnt_nxt;
  logic [7:0]  held_blue_r, held_blue_nxt;
  logic [7:0]  held_green_r, held_green_nxt;

  logic        restart;
  logic        in_hdr;
  logic        in_pix;
  logic [5:0]  n;
  logic [15:0] sig_cur, bpp_cur, sig_new, bpp_new;
  logic [31:0] width_cur, height_cur;
  logic        sig_bad, bpp_bad, too_big, info_hit, empty;
  logic        px_emit, row_end, px_final, key;
  logic [12:0] col_inc, frow_inc;
  logic [11:0] row_num;

  function automatic logic [12:0] next_pow2(logic [12:0] v);
    logic [12:0] p;
    p = 13'd1 << 12;
    for (int i = 12; i >= 0; i--) begin
      if ((13'd1 << i) >= v) begin
        p = 13'd1 << i;
      end
    end
    return p;
  endfunction

  // A start mark restarts the parse with this byte as header byte zero.
  assign restart    = step && item.file_start;
  assign phase_eff  = restart ? PH_HEADER : phase_r;
  assign in_hdr     = step && (phase_eff == PH_HEADER);
  assign in_pix     = step && (phase_eff == PH_PIXELS);
  assign n          = restart ? '0 : hdr_cnt_r;
  assign sig_cur    = restart ? '0 : sig_r;
  assign bpp_cur    = restart ? '0 : bpp_r;
  assign width_cur  = restart ? '0 : width_r;
  assign height_cur = restart ? '0 : height_r;
  assign sig_new    = {item.data_byte, sig_cur[15:8]};
  assign bpp_new    = {item.data_byte, bpp_cur[15:8]};

  assign sig_bad  = in_hdr && (n == HDR_SIG_HI) && (sig_new != SIGNATURE);
  assign bpp_bad  = in_hdr && (n == HDR_BPP_HI) && (bpp_new != BPP_24);
  assign too_big  = in_hdr && (n == HDR_BPP_HI) && !bpp_bad &&
                    ((width_cur > 32'(MAX_DIM)) || (height_cur > 32'(MAX_DIM)));
  assign info_hit = in_hdr && (n >= HDR_LAST);
  assign empty    = (width_cur == '0) || (height_cur == '0);

  assign col_inc  = col_cnt_r + 13'd1;
  assign frow_inc = frow_cnt_r + 13'd1;
  assign px_emit  = in_pix && (pad_cnt_r == '0) && (byte_ph_r == 2'd2);
  assign row_end  = col_inc >= width_r[12:0];
  assign px_final = row_end && (frow_inc >= height_r[12:0]);
  assign row_num  = height_r[11:0] - 12'd1 - frow_cnt_r[11:0];
  assign key      = (item.data_byte == FULL) && (held_green_r == '0) &&
                    (held_blue_r == FULL);

  // Phase sequencing
  always_comb begin
    phase_nxt = phase_eff;
    unique case (phase_eff)
      PH_HEADER: begin
        if (sig_bad || bpp_bad || too_big) begin
          phase_nxt = PH_DONE;
        end else if (info_hit) begin
          phase_nxt = empty ? PH_DONE : PH_PIXELS;
        end
      end
      PH_PIXELS: begin
        if (px_emit && px_final) begin
          phase_nxt = PH_DONE;
        end
      end
      PH_IDLE, PH_DONE: begin
        phase_nxt = phase_eff;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Field capture and pixel counters
  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    sig_nxt        = sig_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    bpp_nxt        = bpp_r;
    col_cnt_nxt    = col_cnt_r;
    frow_cnt_nxt   = frow_cnt_r;
    byte_ph_nxt    = byte_ph_r;
    pad_cnt_nxt    = pad_cnt_r;
    held_blue_nxt  = held_blue_r;
    held_green_nxt = held_green_r;
    if (restart) begin
      sig_nxt      = '0;
      width_nxt    = '0;
      height_nxt   = '0;
      bpp_nxt      = '0;
      col_cnt_nxt  = '0;
      frow_cnt_nxt = '0;
      byte_ph_nxt  = '0;
      pad_cnt_nxt  = '0;
    end
    if (in_hdr) begin
      hdr_cnt_nxt = n + 6'd1;
      if (n <= HDR_SIG_HI) begin
        sig_nxt = sig_new;
      end else if ((n >= HDR_W_LO) && (n <= HDR_W_HI)) begin
        width_nxt = {item.data_byte, width_cur[31:8]};
      end else if ((n >= HDR_H_LO) && (n <= HDR_H_HI)) begin
        height_nxt = {item.data_byte, height_cur[31:8]};
      end else if ((n == HDR_BPP_LO) || (n == HDR_BPP_HI)) begin
        bpp_nxt = bpp_new;
      end else if (n >= HDR_LAST) begin
        col_cnt_nxt  = '0;
        frow_cnt_nxt = '0;
        byte_ph_nxt  = '0;
        pad_cnt_nxt  = '0;
      end
    end
    if (in_pix) begin
      if (pad_cnt_r != '0) begin
        pad_cnt_nxt = pad_cnt_r - 2'd1;
      end else if (byte_ph_r == 2'd0) begin
        held_blue_nxt = item.data_byte;
        byte_ph_nxt   = 2'd1;
      end else if (byte_ph_r == 2'd1) begin
        held_green_nxt = item.data_byte;
        byte_ph_nxt    = 2'd2;
      end else begin
        byte_ph_nxt = 2'd0;
        if (!px_final) begin
          if (row_end) begin
            col_cnt_nxt  = '0;
            frow_cnt_nxt = frow_inc;
            pad_cnt_nxt  = width_r[1:0];
          end else begin
            col_cnt_nxt = col_inc;
          end
        end
      end
    end
  end

  // Result formation
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    if (sig_bad) begin
      res_valid = 1'b1;
      res.kind  = KIND_BAD_SIG;
    end else if (bpp_bad) begin
      res_valid = 1'b1;
      res.kind  = KIND_BAD_BPP;
    end else if (too_big) begin
      res_valid = 1'b1;
      res.kind  = KIND_TOO_BIG;
    end else if (info_hit) begin
      res_valid        = 1'b1;
      res.kind         = KIND_INFO;
      res.tex_width    = next_pow2(width_cur[12:0]);
      res.tex_height   = next_pow2(height_cur[12:0]);
      res.image_width  = width_cur[12:0];
      res.image_height = height_cur[12:0];
      res.last         = empty;
    end else if (px_emit) begin
      res_valid = 1'b1;
      res.kind  = KIND_PIXEL;
      res.red   = item.data_byte;
      res.green = held_green_r;
      res.blue  = held_blue_r;
      res.alpha = key ? 8'd0 : FULL;
      res.col   = col_cnt_r[11:0];
      res.row   = row_num;
      res.last  = px_final;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      hdr_cnt_r  <= '0;
      col_cnt_r  <= '0;
      frow_cnt_r <= '0;
      byte_ph_r  <= '0;
      pad_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      col_cnt_r  <= col_cnt_nxt;
      frow_cnt_r <= frow_cnt_nxt;
      byte_ph_r  <= byte_ph_nxt;
      pad_cnt_r  <= pad_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sig_r        <= sig_nxt;
    width_r      <= width_nxt;
    height_r     <= height_nxt;
    bpp_r        <= bpp_nxt;
    held_blue_r  <= held_blue_nxt;
    held_green_r <= held_green_nxt;
  end

endmodule

// ===== rtl/core/bmp24_to_rgba_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// bmp24_to_rgba_decoder_unit
// Path: an accepted byte is held in the input register, then passes through
// the parser into the result register, from which its result is taken.
// Throughput: one byte per cycle while results drain; a waiting result holds
// the parser, so the input register takes one more byte and then stalls.
// Reset: synchronous, active low; clears both stages and the parse phase.
// ----------------------------------------------------------------------------
module bmp24_to_rgba_decoder_unit (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bmpdec_pkg::bmpdec_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bmpdec_pkg::bmpdec_out_t  out_data
);
  import bmpdec_pkg::*;

  logic        in_valid_r;
  bmpdec_in_t  in_item_r;
  logic        out_valid_r;
  bmpdec_out_t out_item_r;
  logic        advance;
  logic        res_valid;
  bmpdec_out_t res;

  // Move the held byte through the parser whenever the result slot is free.
  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  bmpdec_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= res_valid;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (advance && res_valid) begin
      out_item_r <= res;
    end
  end

  a_no_needless_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && (!out_valid_r || out_ready)) |-> in_ready)
    else $error("input stage stalled with a free result slot");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> (!out_valid_r && !in_valid_r))
    else $error("pipeline not empty after reset");

  a_key_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.kind == KIND_PIXEL) && (out_item_r.alpha == 8'd0)) |->
    ((out_item_r.red == 8'hFF) && (out_item_r.green == 8'd0) && (out_item_r.blue == 8'hFF)))
    else $error("transparent pixel is not the key color");

  a_tex_covers: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_item_r.kind == KIND_INFO)) |->
    ((out_item_r.tex_width >= out_item_r.image_width) &&
     (out_item_r.tex_height >= out_item_r.image_height)))
    else $error("texture size below image size");

endmodule
